[rtl/sui_pkg.sv]
`timescale 1ns / 1ps

package sui_pkg;

    // Fixed field widths.
    localparam int VAL_W    = 32;
    localparam int REQ_W    = 2;
    localparam int KIND_W   = 3;
    localparam int UCNT_W   = 6;
    localparam int ICNT_W   = 5;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;
    localparam int M_PAD_W  = M_DATA_W - VAL_W - UCNT_W - ICNT_W;

    // Request codes carried on the slave-side tuser.
    localparam logic [REQ_W-1:0] REQ_ADD_A   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD_B   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPUTE = 2'd2;

    // Result kinds carried on the master-side tuser.
    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED  = 3'd0,
        KIND_DUPLICATE = 3'd1,
        KIND_FULL      = 3'd2,
        KIND_UNION     = 3'd3,
        KIND_INTER     = 3'd4,
        KIND_DONE      = 3'd5
    } kind_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_SCAN,
        ST_ADD_END,
        ST_UNI_A,
        ST_UNI_B,
        ST_UNI_END,
        ST_INT_LOAD,
        ST_INT_WAIT,
        ST_INT_SCAN,
        ST_INT_END,
        ST_DONE
    } state_t;

    // Operands of the shared compare unit.
    typedef struct packed {
        logic [VAL_W-1:0] word;
        logic [VAL_W-1:0] key;
        logic [VAL_W-1:0] floor_val;
        logic             floor_vld;
        logic [VAL_W-1:0] best_val;
        logic             best_vld;
    } cmp_op_t;

    // Results of the shared compare unit.
    typedef struct packed {
        logic eq;
        logic above_floor;
        logic below_best;
    } cmp_res_t;

    // One result word handed from the sequencer to the output register.
    typedef struct packed {
        kind_t             kind;
        logic [VAL_W-1:0]  elem;
        logic [UCNT_W-1:0] ucnt;
        logic [ICNT_W-1:0] icnt;
        logic              last;
    } res_t;

endpackage

[rtl/set_union_intersection.sv]
`timescale 1ns / 1ps
// Channel   Direction  Ports                          Contents
// s_*       in         tvalid tready tdata tuser      request word
// m_*       out        tvalid tready tdata tuser tlast result word
//
// An add request reads each entry of the target store once through the
// shared compare unit, then answers.
// A compute request runs one selection pass over both stores per union
// element and a last pass that finds none, then scans set B for each set A entry.
// Reset empties both sets; store contents are not cleared.
// A stalled result holds in the output register and the sequencer waits.

module set_union_intersection
    import sui_pkg::*;
#(
    parameter int SET_CAP = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // [31:0] value
    input  logic [REQ_W-1:0]    s_tuser,  // [1:0] req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // [31:0] elem_value, [37:32] union_count,
                                          // [42:38] inter_count, [47:43] zero
    output logic [KIND_W-1:0]   m_tuser,  // [2:0] kind
    output logic                m_tlast
);

    localparam int AW    = (SET_CAP > 1) ? $clog2(SET_CAP) : 1;
    localparam int CNT_W = $clog2(SET_CAP + 1);

    logic             a_we, b_we;
    logic [AW-1:0]    a_waddr, a_raddr, b_waddr, b_raddr;
    logic [VAL_W-1:0] a_rdata, b_rdata, wdata;
    cmp_op_t          cmp_op;
    cmp_res_t         cmp_res;
    logic             emit_vld;
    res_t             emit_res;
    logic             slot_free;
    logic             m_vld_reg, m_vld_next;
    res_t             m_res_reg;

    // Set stores.
    sui_ram #(.WIDTH(VAL_W), .DEPTH(SET_CAP)) u_ram_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    sui_ram #(.WIDTH(VAL_W), .DEPTH(SET_CAP)) u_ram_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Shared compare unit.
    sui_cmp u_cmp (
        .op  (cmp_op),
        .res (cmp_res)
    );

    // Sequencer.
    sui_ctrl #(.SET_CAP(SET_CAP), .AW(AW), .CNT_W(CNT_W)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .in_value  (s_tdata),
        .a_we      (a_we),
        .a_waddr   (a_waddr),
        .a_raddr   (a_raddr),
        .a_rdata   (a_rdata),
        .b_we      (b_we),
        .b_waddr   (b_waddr),
        .b_raddr   (b_raddr),
        .b_rdata   (b_rdata),
        .wdata     (wdata),
        .cmp_op    (cmp_op),
        .cmp_res   (cmp_res),
        .emit_vld  (emit_vld),
        .emit_res  (emit_res),
        .slot_free (slot_free)
    );

    // Output register: a new word loads when the slot is empty or draining.
    assign slot_free  = !m_vld_reg || m_tready;
    assign m_vld_next = (emit_vld && slot_free) || (m_vld_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= m_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_vld && slot_free)
        begin
            m_res_reg <= emit_res;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_res_reg.icnt, m_res_reg.ucnt, m_res_reg.elem};
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last;

endmodule

[rtl/sui_ram.sv]
`timescale 1ns / 1ps

module sui_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sui_cmp.sv]
`timescale 1ns / 1ps

module sui_cmp
    import sui_pkg::*;
(
    input  cmp_op_t  op,
    output cmp_res_t res
);

    // Equality against the search key, and signed order against the
    // current lower bound and the best candidate so far.
    always_comb
    begin
        res.eq          = (op.word == op.key);
        res.above_floor = !op.floor_vld || ($signed(op.word) > $signed(op.floor_val));
        res.below_best  = !op.best_vld || ($signed(op.word) < $signed(op.best_val));
    end

endmodule

[rtl/sui_ctrl.sv]
`timescale 1ns / 1ps

module sui_ctrl
    import sui_pkg::*;
#(
    parameter int SET_CAP = 16,
    parameter int AW      = (SET_CAP > 1) ? $clog2(SET_CAP) : 1,
    parameter int CNT_W   = $clog2(SET_CAP + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    // Request side
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [REQ_W-1:0] in_req,
    input  logic [VAL_W-1:0] in_value,
    // Set A store
    output logic             a_we,
    output logic [AW-1:0]    a_waddr,
    output logic [AW-1:0]    a_raddr,
    input  logic [VAL_W-1:0] a_rdata,
    // Set B store
    output logic             b_we,
    output logic [AW-1:0]    b_waddr,
    output logic [AW-1:0]    b_raddr,
    input  logic [VAL_W-1:0] b_rdata,
    output logic [VAL_W-1:0] wdata,
    // Shared compare unit
    output cmp_op_t          cmp_op,
    input  cmp_res_t         cmp_res,
    // Result side
    output logic             emit_vld,
    output res_t             emit_res,
    input  logic             slot_free
);

    localparam logic [CNT_W-1:0] CAP = CNT_W'(SET_CAP);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]  cnt_b_reg, cnt_b_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic [CNT_W-1:0]  int_i_reg, int_i_next;
    logic              chk_vld_reg, chk_vld_next;
    logic              sel_b_reg, sel_b_next;
    logic              hit_reg, hit_next;
    logic              floor_vld_reg, floor_vld_next;
    logic              best_vld_reg, best_vld_next;
    logic [UCNT_W-1:0] ucnt_reg, ucnt_next;
    logic [ICNT_W-1:0] icnt_reg, icnt_next;
    logic [VAL_W-1:0]  key_reg, key_next;
    logic [VAL_W-1:0]  floor_reg, floor_next;
    logic [VAL_W-1:0]  best_reg, best_next;

    logic              scanning;
    logic [CNT_W-1:0]  n_cur;
    logic [VAL_W-1:0]  word;
    logic              issue;
    logic              scan_done;
    logic [CNT_W-1:0]  cnt_sel;
    logic              is_full;

    // Length of the current scan and the store word that it checks.
    always_comb
    begin
        scanning = 1'b0;
        n_cur    = '0;
        word     = b_rdata;
        unique case (state_reg)
            ST_ADD_SCAN:
            begin
                scanning = 1'b1;
                n_cur    = sel_b_reg ? cnt_b_reg : cnt_a_reg;
                word     = sel_b_reg ? b_rdata : a_rdata;
            end
            ST_UNI_A:
            begin
                scanning = 1'b1;
                n_cur    = cnt_a_reg;
                word     = a_rdata;
            end
            ST_UNI_B, ST_INT_SCAN:
            begin
                scanning = 1'b1;
                n_cur    = cnt_b_reg;
            end
            default:
            begin
                scanning = 1'b0;
            end
        endcase
    end

    // A scan issues one read a cycle and checks the word in the next cycle.
    assign issue     = scanning && (iss_reg < n_cur);
    assign scan_done = scanning && !issue && !chk_vld_reg;
    assign cnt_sel   = sel_b_reg ? cnt_b_reg : cnt_a_reg;
    assign is_full   = (cnt_sel >= CAP);

    assign a_raddr  = (state_reg == ST_INT_LOAD) ? int_i_reg[AW-1:0] : iss_reg[AW-1:0];
    assign b_raddr  = iss_reg[AW-1:0];
    assign a_waddr  = cnt_a_reg[AW-1:0];
    assign b_waddr  = cnt_b_reg[AW-1:0];
    assign wdata    = key_reg;
    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmp_op.word      = word;
        cmp_op.key       = key_reg;
        cmp_op.floor_val = floor_reg;
        cmp_op.floor_vld = floor_vld_reg;
        cmp_op.best_val  = best_reg;
        cmp_op.best_vld  = best_vld_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_req == REQ_ADD_A || in_req == REQ_ADD_B)
                    begin
                        state_next = ST_ADD_SCAN;
                    end
                    else if (in_req == REQ_COMPUTE)
                    begin
                        state_next = ST_UNI_A;
                    end
                end
            end
            ST_ADD_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_ADD_END;
                end
            end
            ST_ADD_END:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_UNI_A:
            begin
                if (scan_done)
                begin
                    state_next = ST_UNI_B;
                end
            end
            ST_UNI_B:
            begin
                if (scan_done)
                begin
                    state_next = ST_UNI_END;
                end
            end
            ST_UNI_END:
            begin
                if (!best_vld_reg)
                begin
                    state_next = ST_INT_LOAD;
                end
                else if (slot_free)
                begin
                    state_next = ST_UNI_A;
                end
            end
            ST_INT_LOAD:
            begin
                state_next = (int_i_reg < cnt_a_reg) ? ST_INT_WAIT : ST_DONE;
            end
            ST_INT_WAIT:
            begin
                state_next = ST_INT_SCAN;
            end
            ST_INT_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_INT_END;
                end
            end
            ST_INT_END:
            begin
                if (!hit_reg || slot_free)
                begin
                    state_next = ST_INT_LOAD;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath updates, store writes and result words.
    always_comb
    begin
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        iss_next       = issue ? iss_reg + 1'b1 : iss_reg;
        chk_vld_next   = issue;
        int_i_next     = int_i_reg;
        sel_b_next     = sel_b_reg;
        hit_next       = hit_reg;
        floor_vld_next = floor_vld_reg;
        best_vld_next  = best_vld_reg;
        ucnt_next      = ucnt_reg;
        icnt_next      = icnt_reg;
        key_next       = key_reg;
        floor_next     = floor_reg;
        best_next      = best_reg;
        a_we           = 1'b0;
        b_we           = 1'b0;
        emit_vld       = 1'b0;
        emit_res       = '0;

        if (scan_done)
        begin
            iss_next = '0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                iss_next       = '0;
                sel_b_next     = (in_req == REQ_ADD_B);
                key_next       = in_value;
                hit_next       = 1'b0;
                floor_vld_next = 1'b0;
                best_vld_next  = 1'b0;
                ucnt_next      = '0;
                icnt_next      = '0;
            end
            ST_ADD_SCAN, ST_INT_SCAN:
            begin
                if (chk_vld_reg && cmp_res.eq)
                begin
                    hit_next = 1'b1;
                end
            end
            ST_ADD_END:
            begin
                emit_vld      = 1'b1;
                emit_res.last = 1'b1;
                if (hit_reg)
                begin
                    emit_res.kind = KIND_DUPLICATE;
                end
                else if (is_full)
                begin
                    emit_res.kind = KIND_FULL;
                end
                else
                begin
                    emit_res.kind = KIND_ACCEPTED;
                end
                if (slot_free && !hit_reg && !is_full)
                begin
                    a_we = !sel_b_reg;
                    b_we = sel_b_reg;
                    if (sel_b_reg)
                    begin
                        cnt_b_next = cnt_b_reg + 1'b1;
                    end
                    else
                    begin
                        cnt_a_next = cnt_a_reg + 1'b1;
                    end
                end
            end
            ST_UNI_A, ST_UNI_B:
            begin
                // Keep the smallest word above the last emitted element.
                if (chk_vld_reg && cmp_res.above_floor && cmp_res.below_best)
                begin
                    best_next     = word;
                    best_vld_next = 1'b1;
                end
            end
            ST_UNI_END:
            begin
                if (!best_vld_reg)
                begin
                    int_i_next = '0;
                end
                else
                begin
                    emit_vld      = 1'b1;
                    emit_res.kind = KIND_UNION;
                    emit_res.elem = best_reg;
                    if (slot_free)
                    begin
                        floor_next     = best_reg;
                        floor_vld_next = 1'b1;
                        best_vld_next  = 1'b0;
                        ucnt_next      = ucnt_reg + 1'b1;
                    end
                end
            end
            ST_INT_LOAD:
            begin
                hit_next = 1'b0;
            end
            ST_INT_WAIT:
            begin
                key_next = a_rdata;
            end
            ST_INT_END:
            begin
                if (!hit_reg)
                begin
                    int_i_next = int_i_reg + 1'b1;
                end
                else
                begin
                    emit_vld      = 1'b1;
                    emit_res.kind = KIND_INTER;
                    emit_res.elem = key_reg;
                    if (slot_free)
                    begin
                        int_i_next = int_i_reg + 1'b1;
                        icnt_next  = icnt_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                emit_vld      = 1'b1;
                emit_res.kind = KIND_DONE;
                emit_res.ucnt = ucnt_reg;
                emit_res.icnt = icnt_reg;
                emit_res.last = 1'b1;
                if (slot_free)
                begin
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                end
            end
            default:
            begin
                emit_vld = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            iss_reg       <= '0;
            int_i_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            sel_b_reg     <= 1'b0;
            hit_reg       <= 1'b0;
            floor_vld_reg <= 1'b0;
            best_vld_reg  <= 1'b0;
            ucnt_reg      <= '0;
            icnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            iss_reg       <= iss_next;
            int_i_reg     <= int_i_next;
            chk_vld_reg   <= chk_vld_next;
            sel_b_reg     <= sel_b_next;
            hit_reg       <= hit_next;
            floor_vld_reg <= floor_vld_next;
            best_vld_reg  <= best_vld_next;
            ucnt_reg      <= ucnt_next;
            icnt_reg      <= icnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        floor_reg <= floor_next;
        best_reg  <= best_next;
    end

endmodule

[rtl/sui_chk.sv]
`timescale 1ns / 1ps

module sui_chk
    import sui_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [REQ_W-1:0]    s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [KIND_W-1:0]   m_tuser,
    input logic                m_tlast
);

    // A stalled result word holds still.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result word changed");

    // Once a real request is taken the block is busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready &&
        (s_tuser == REQ_ADD_A || s_tuser == REQ_ADD_B || s_tuser == REQ_COMPUTE)
        |=> !s_tready)
        else $error("request accepted while previous one still in work");

    // Status and done words close their request; element words never do.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser != KIND_UNION && m_tuser != KIND_INTER)))
        else $error("last flag does not match result kind");

    // Add status words carry no element and no counts.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ACCEPTED || m_tuser == KIND_DUPLICATE ||
                     m_tuser == KIND_FULL)
        |-> m_tdata == '0)
        else $error("status word carries data");

    // Element words carry no counts.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_UNION || m_tuser == KIND_INTER)
        |-> m_tdata[M_DATA_W-1:VAL_W] == '0)
        else $error("element word carries counts");

endmodule

bind set_union_intersection sui_chk u_sui_chk (.*);
